[design/psg_pkg.sv]
`default_nettype none
package psg_pkg;

  localparam int SCALE_W  = 24;
  localparam int PERIOD_W = 10;
  localparam int SAMPLE_W = 15;
  localparam int VOL_W    = 13;
  localparam int CNT_W    = 17;
  localparam int SR_W     = 16;
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 24'd332467;
  localparam logic [SR_W-1:0]    SR_START       = 16'h8000;
  localparam logic [3:0]         ATTEN_MUTE     = 4'hF;
  localparam logic [2:0]         LATCH_RST      = 3'd7;
  localparam logic [1:0]         CH_TONE2       = 2'd2;
  localparam logic [1:0]         CH_NOISE       = 2'd3;
  localparam logic [1:0]         RATE_TONE2     = 2'd3;
  localparam logic [1:0]         RATE_DIV32     = 2'd0;
  localparam logic [1:0]         RATE_DIV64     = 2'd1;
  localparam logic [1:0]         RATE_DIV128    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_TICK,
    S_EMIT
  } psg_state_t;

  typedef struct packed {
    logic                start;
    logic [SCALE_W-1:0]  dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] quotient;
  } div_rsp_t;

  // 2 dB steps, last entry is mute
  function automatic logic [VOL_W-1:0] vol_level(input logic [3:0] atten);
    logic [VOL_W-1:0] v;
    unique case (atten)
      4'd0:    v = 13'd6826;
      4'd1:    v = 13'd5422;
      4'd2:    v = 13'd4307;
      4'd3:    v = 13'd3421;
      4'd4:    v = 13'd2717;
      4'd5:    v = 13'd2158;
      4'd6:    v = 13'd1714;
      4'd7:    v = 13'd1362;
      4'd8:    v = 13'd1081;
      4'd9:    v = 13'd859;
      4'd10:   v = 13'd682;
      4'd11:   v = 13'd542;
      4'd12:   v = 13'd430;
      4'd13:   v = 13'd342;
      4'd14:   v = 13'd271;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/psg_if.sv]
`default_nettype none
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data;
  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

interface psg_out_if;
  logic                          valid;
  logic                          ready;
  logic [psg_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface psg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [psg_pkg::SCALE_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/psg_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module psg_div (
  input  wire               clk,
  input  wire               rst_n,
  input  psg_pkg::div_req_t req,
  output psg_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [psg_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [psg_pkg::SCALE_W-1:0]       q_r;
  logic [psg_pkg::PERIOD_W-1:0]      rem_r;
  logic [psg_pkg::PERIOD_W-1:0]      div_r;

  logic [psg_pkg::PERIOD_W:0]        trial;
  logic [psg_pkg::PERIOD_W:0]        diff;
  logic                              q_bit;
  logic [psg_pkg::PERIOD_W-1:0]      rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[psg_pkg::SCALE_W-1]};
    diff    = trial - {1'b0, div_r};
    q_bit   = (trial >= {1'b0, div_r});
    rem_nxt = q_bit ? diff[psg_pkg::PERIOD_W-1:0] : trial[psg_pkg::PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == psg_pkg::DIV_CNT_W'(psg_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[psg_pkg::SCALE_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
`default_nettype wire

[design/psg_tone_noise_generator.sv]
// Three square-wave tone channels and one noise channel. A write beat (func 0)
// carries a latch or data byte; a tick beat (func 1) returns one mixed sample.
// Volume and noise writes are registered as the beat is taken. A tone write recomputes that
// channel's phase step as step_scale / period in a restoring divider that
// yields one quotient bit per cycle, so the input is not ready until the
// divider is done. A tick walks the four channels through one shared 17-bit phase
// adder, one channel per cycle, and its sample is registered in S_EMIT after the
// noise channel, later while the output still holds an unread sample. The
// input is not ready while a tone write or a tick is in progress; cfg writes are
// always taken.
`default_nettype none
module psg_tone_noise_generator #(
  parameter int STEP_BITS = 24
) (
  input  wire          clk,
  input  wire          rst_n,
  psg_in_if.sink       in_bus,
  psg_out_if.source    out_bus,
  psg_cfg_if.sink      cfg_bus
);

  localparam int CW = psg_pkg::CNT_W;

  function automatic logic [STEP_BITS-1:0] fit_step(input logic [psg_pkg::SCALE_W-1:0] v);
    logic [31:0] w;
    w = {8'd0, v};
    return w[STEP_BITS-1:0];
  endfunction

  psg_pkg::psg_state_t state_r, state_nxt;

  logic [psg_pkg::SCALE_W-1:0]  step_scale_r;
  logic [2:0]                   latched_r;
  logic [psg_pkg::PERIOD_W-1:0] tone_period_r [3];
  logic [3:0]                   atten_r [4];
  logic [1:0]                   noise_rate_r;
  logic                         white_r;
  logic [STEP_BITS-1:0]         tone_step_r [3];
  logic [STEP_BITS-1:0]         noise_step_r;
  logic [CW-1:0]                phase_r [4];
  logic [psg_pkg::SR_W-1:0]     sr_r;
  logic [1:0]                   chan_r;
  logic [1:0]                   div_ch_r;
  logic [psg_pkg::SAMPLE_W-1:0] sum_r;
  logic [psg_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                         out_valid_r;

  psg_pkg::div_req_t div_req;
  psg_pkg::div_rsp_t div_rsp;

  logic                         in_ready;
  logic                         in_fire;
  logic                         cfg_fire;
  logic                         emit_load;

  // write decode
  logic [2:0]                   wr_idx;
  logic [1:0]                   wr_ch;
  logic [psg_pkg::PERIOD_W-1:0] cur_period;
  logic [psg_pkg::PERIOD_W-1:0] new_period;
  logic                         tone_wr;
  logic [STEP_BITS-1:0]         noise_sel;
  logic [STEP_BITS-1:0]         q_fit;

  // tick datapath
  logic [STEP_BITS-1:0]         st_sel;
  logic [CW-1:0]                pc_sum;
  logic [CW-1:0]                phase_new;
  logic [3:0]                   atten_sel;
  logic [psg_pkg::VOL_W-1:0]    vol;
  logic                         audible;
  logic [psg_pkg::SR_W-1:0]     sr_new;
  logic                         fb;
  logic [psg_pkg::SAMPLE_W-1:0] sum_nxt;

  psg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_fire  = in_bus.valid && in_ready;
  assign cfg_fire = cfg_bus.valid;

  always_comb begin
    wr_idx = in_bus.data[7] ? in_bus.data[6:4] : latched_r;
    wr_ch  = wr_idx[2:1];
    unique case (wr_ch)
      2'd0:    cur_period = tone_period_r[0];
      2'd1:    cur_period = tone_period_r[1];
      2'd2:    cur_period = tone_period_r[2];
      default: cur_period = '0;
    endcase
    if (in_bus.data[7]) begin
      new_period = {cur_period[psg_pkg::PERIOD_W-1:4], in_bus.data[3:0]};
    end else begin
      new_period = {in_bus.data[5:0], cur_period[3:0]};
    end
    tone_wr = !wr_idx[0] && (wr_ch != psg_pkg::CH_NOISE);
    unique case (in_bus.data[1:0])
      psg_pkg::RATE_DIV32:  noise_sel = fit_step(step_scale_r >> 5);
      psg_pkg::RATE_DIV64:  noise_sel = fit_step(step_scale_r >> 6);
      psg_pkg::RATE_DIV128: noise_sel = fit_step(step_scale_r >> 7);
      default:              noise_sel = tone_step_r[2] >> 1;
    endcase
    q_fit = fit_step(div_rsp.quotient);
  end

  // one channel per tick cycle through the shared phase adder
  always_comb begin
    unique case (chan_r)
      2'd0:    st_sel = tone_step_r[0];
      2'd1:    st_sel = tone_step_r[1];
      2'd2:    st_sel = tone_step_r[2];
      default: st_sel = noise_step_r;
    endcase
    atten_sel = atten_r[chan_r];
    vol       = psg_pkg::vol_level(atten_sel);
    pc_sum    = phase_r[chan_r] + st_sel[CW-1:0];
    phase_new = pc_sum;
    sr_new    = sr_r;
    fb        = white_r ? (sr_r[0] ^ sr_r[3]) : sr_r[0];
    if (chan_r == psg_pkg::CH_NOISE) begin
      audible = (atten_sel != psg_pkg::ATTEN_MUTE) && sr_r[0];
      if ((atten_sel != psg_pkg::ATTEN_MUTE) && pc_sum[CW-1]) begin
        phase_new[CW-1] = 1'b0;
        sr_new = {fb, sr_r[psg_pkg::SR_W-1:1]};
      end
    end else begin
      // a step at or above half a phase cycle pins the channel high
      audible = (atten_sel != psg_pkg::ATTEN_MUTE) &&
                ((|st_sel[STEP_BITS-1:CW-1]) || pc_sum[CW-1]);
    end
    sum_nxt = audible ? (sum_r + {2'b00, vol}) : sum_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psg_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_bus.func) state_nxt = psg_pkg::S_TICK;
          else if (tone_wr) state_nxt = psg_pkg::S_DIV;
        end
      end
      psg_pkg::S_DIV: begin
        if (div_rsp.done) state_nxt = psg_pkg::S_IDLE;
      end
      psg_pkg::S_TICK: begin
        if (chan_r == psg_pkg::CH_NOISE) state_nxt = psg_pkg::S_EMIT;
      end
      psg_pkg::S_EMIT: begin
        if (!out_valid_r || out_bus.ready) state_nxt = psg_pkg::S_IDLE;
      end
      default: state_nxt = psg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = (state_r == psg_pkg::S_IDLE);
    emit_load         = (state_r == psg_pkg::S_EMIT) && (!out_valid_r || out_bus.ready);
    div_req.start     = in_fire && !in_bus.func && tone_wr;
    div_req.dividend  = step_scale_r;
    div_req.divisor   = (new_period == '0) ? psg_pkg::PERIOD_W'(1) : new_period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psg_pkg::S_IDLE;
      step_scale_r <= psg_pkg::STEP_SCALE_RST;
      latched_r    <= psg_pkg::LATCH_RST;
      for (int i = 0; i < 3; i++) begin
        tone_period_r[i] <= '0;
        tone_step_r[i]   <= fit_step(psg_pkg::STEP_SCALE_RST);
      end
      for (int i = 0; i < 4; i++) begin
        atten_r[i] <= psg_pkg::ATTEN_MUTE;
        phase_r[i] <= '0;
      end
      noise_rate_r <= psg_pkg::RATE_DIV32;
      white_r      <= 1'b0;
      noise_step_r <= fit_step(psg_pkg::STEP_SCALE_RST >> 5);
      sr_r         <= psg_pkg::SR_START;
      chan_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) step_scale_r <= cfg_bus.data;

      if (in_fire && !in_bus.func) begin
        latched_r <= wr_idx;
        if (wr_idx[0]) begin
          atten_r[wr_ch] <= in_bus.data[3:0];
        end else if (wr_ch != psg_pkg::CH_NOISE) begin
          tone_period_r[wr_ch] <= new_period;
        end else begin
          sr_r         <= psg_pkg::SR_START;
          noise_rate_r <= in_bus.data[1:0];
          white_r      <= in_bus.data[2];
          noise_step_r <= noise_sel;
        end
      end

      if (in_fire && in_bus.func) chan_r <= '0;

      if ((state_r == psg_pkg::S_DIV) && div_rsp.done) begin
        tone_step_r[div_ch_r] <= q_fit;
        // noise tracks tone 2 while its rate select points there
        if ((div_ch_r == psg_pkg::CH_TONE2) && (noise_rate_r == psg_pkg::RATE_TONE2)) begin
          noise_step_r <= q_fit >> 1;
        end
      end

      if (state_r == psg_pkg::S_TICK) begin
        phase_r[chan_r] <= phase_new;
        chan_r          <= chan_r + 1'b1;
        if (chan_r == psg_pkg::CH_NOISE) sr_r <= sr_new;
      end

      if (emit_load) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) div_ch_r <= wr_ch;
    if (in_fire && in_bus.func) sum_r <= '0;
    else if (state_r == psg_pkg::S_TICK) sum_r <= sum_nxt;
    if (emit_load) out_sample_r <= sum_r;
  end

  assign in_bus.ready   = in_ready;
  assign cfg_bus.ready  = 1'b1;
  assign out_bus.valid  = out_valid_r;
  assign out_bus.sample = out_sample_r;

endmodule
`default_nettype wire

[design/psg_checker.sv]
`default_nettype none
module psg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [14:0] out_sample
);

  // a beat held back on the output stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample))
    else $error("result payload changed while stalled");

  a_sample_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample <= 15'd27304)
    else $error("sample above full-scale mix");

  // a tick needs its channel steps and S_EMIT before its result appears
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after an input beat");

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample)
);
`default_nettype wire
